// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define KLEX_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check that a condition implies another at the same clock edge.
`define KLEX_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies another at the next clock edge.
`define KLEX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KLEX_ASSERT_ALWAYS(label, cond, msg)
`define KLEX_ASSERT_IMPLIES(label, ante, cons, msg)
`define KLEX_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/klex_pkg.sv =====
// Types, constants and keyword helpers for the keyword token lexer.
`default_nettype none
package klex_pkg;
	// Longest token kept; longer tokens are cut and flagged
	localparam int TOKEN_LIMIT = 255;
	localparam int RUN_W = $clog2(TOKEN_LIMIT + 1);
	localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(TOKEN_LIMIT);

	// Most results one byte can cause, and the result queue depth
	localparam int MAX_RES = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// Token type codes
	localparam logic [2:0] TYPE_IDENT = 3'd0;
	localparam logic [2:0] TYPE_NUMBER = 3'd1;
	localparam logic [2:0] TYPE_OPERATOR = 3'd2;
	localparam logic [2:0] TYPE_KEYWORD = 3'd3;
	localparam logic [2:0] TYPE_END = 3'd4;

	// Record kind codes
	localparam logic REC_ECHO = 1'b0;
	localparam logic REC_CLOSE = 1'b1;

	// Scan mode
	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_IDENT = 3'b010,
		MODE_NUMBER = 3'b100
	} mode_t;

	// Keyword spellings, padded with zero bytes
	localparam logic [7:0] KW_TEXT [4][8] = '{
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [4] = '{3'd2, 3'd4, 3'd5, 3'd6};

	typedef struct packed {
		mode_t mode;
		logic [RUN_W-1:0] run_len;
		logic [3:0] cand;
		logic ovf;
	} lex_state_t;

	localparam lex_state_t LEX_IDLE = '{
		mode: MODE_IDLE, run_len: '0, cand: 4'hF, ovf: 1'b0
	};

	typedef struct packed {
		logic rec_kind;
		logic [7:0] text_char;
		logic [2:0] token_type;
		logic [1:0] keyword_id;
		logic [7:0] token_length;
		logic truncated;
		logic last;
	} res_t;

	typedef struct packed {
		logic room;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

	// Drop keywords that cannot match character c at position pos
	function automatic logic [3:0] cand_next(input logic [3:0] cand,
			input logic [RUN_W-1:0] pos, input logic [7:0] c);
		logic [3:0] keep;
		keep = cand;
		for (int k = 0; k < 4; k++) begin
			if (pos >= RUN_W'(KW_LEN[k]) || KW_TEXT[k][pos[2:0]] != c)
				keep[k] = 1'b0;
		end
		return keep;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/klex_step.sv =====
// Per-byte lexer step: classify a byte, advance the scan state, build results.
`default_nettype none
module klex_step
	import klex_pkg::*;
(
	input wire logic [7:0] ch,
	input wire lex_state_t st,
	output lex_state_t st_n,
	output res_t res [MAX_RES],
	output logic [1:0] res_n
);
	logic is_letter;
	logic is_digit;
	logic is_op;
	logic in_tok;
	logic cont;
	logic [2:0] tok_type;
	res_t close_rec;
	logic kw_hit;
	logic [1:0] kw_id;

	// Classify the byte in the C locale
	assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
	assign is_digit = ch >= 8'h30 && ch <= 8'h39;
	assign is_op = ch == 8'h2B || ch == 8'h2D || ch == 8'h2A || ch == 8'h2F;
	assign in_tok = st.mode == MODE_IDENT || st.mode == MODE_NUMBER;
	assign cont = (st.mode == MODE_IDENT && (is_letter || is_digit)) ||
		(st.mode == MODE_NUMBER && is_digit);
	assign tok_type = (st.mode == MODE_IDENT) ? TYPE_IDENT : TYPE_NUMBER;

	// Find the keyword that the open identifier spells, lowest index first
	always_comb begin
		kw_hit = 1'b0;
		kw_id = 2'd0;
		for (int k = 3; k >= 0; k--) begin
			if (st.cand[k] && st.run_len == RUN_W'(KW_LEN[k])) begin
				kw_hit = 1'b1;
				kw_id = 2'(k);
			end
		end
	end

	// Build the close record for the open token
	always_comb begin
		close_rec = '0;
		close_rec.rec_kind = REC_CLOSE;
		close_rec.token_type = tok_type;
		if (st.mode == MODE_IDENT && !st.ovf && kw_hit) begin
			close_rec.token_type = TYPE_KEYWORD;
			close_rec.keyword_id = kw_id;
		end
		close_rec.token_length = (32'(st.run_len) > 32'd255) ? 8'hFF : 8'(st.run_len);
		close_rec.truncated = st.ovf;
	end

	// Advance the state and list the results in order
	always_comb begin
		st_n = st;
		res = '{default: '0};
		res_n = 2'd0;
		if (cont) begin
			if (st.run_len >= RUN_LIMIT) begin
				st_n.ovf = 1'b1;
			end else begin
				if (st.mode == MODE_IDENT)
					st_n.cand = cand_next(st.cand, st.run_len, ch);
				st_n.run_len = RUN_W'(st.run_len + 1'b1);
				res[res_n].rec_kind = REC_ECHO;
				res[res_n].text_char = ch;
				res[res_n].token_type = tok_type;
				res_n = 2'(res_n + 1'b1);
			end
		end else begin
			if (in_tok) begin
				res[res_n] = close_rec;
				res_n = 2'(res_n + 1'b1);
			end
			st_n = LEX_IDLE;
			if (ch == 8'h00) begin
				res[res_n].rec_kind = REC_CLOSE;
				res[res_n].token_type = TYPE_END;
				res_n = 2'(res_n + 1'b1);
			end else if (is_letter || is_digit) begin
				st_n.mode = is_letter ? MODE_IDENT : MODE_NUMBER;
				st_n.run_len = RUN_W'(1);
				if (is_letter)
					st_n.cand = cand_next(4'hF, '0, ch);
				res[res_n].rec_kind = REC_ECHO;
				res[res_n].text_char = ch;
				res[res_n].token_type = is_letter ? TYPE_IDENT : TYPE_NUMBER;
				res_n = 2'(res_n + 1'b1);
			end else if (is_op) begin
				res[res_n].rec_kind = REC_ECHO;
				res[res_n].text_char = ch;
				res[res_n].token_type = TYPE_OPERATOR;
				res_n = 2'(res_n + 1'b1);
				res[res_n].rec_kind = REC_CLOSE;
				res[res_n].token_type = TYPE_OPERATOR;
				res[res_n].token_length = 8'd1;
				res_n = 2'(res_n + 1'b1);
			end
		end
		// Mark the final result of this byte
		if (res_n != 2'd0)
			res[2'(res_n - 1'b1)].last = 1'b1;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/klex_fifo.sv =====
// Result queue: takes up to three results a cycle, hands out one while the reader is ready.
`default_nettype none
module klex_fifo
	import klex_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire res_t push_data [MAX_RES],
	input wire logic [1:0] push_n,
	input wire logic pop_ready,
	output logic head_valid,
	output res_t head,
	output fifo_stat_t stat
);
	res_t mem [FIFO_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic pop;

	assign head_valid = count_q != '0;
	assign head = mem[rd_ptr_q];
	assign pop = head_valid && pop_ready;
	assign stat.count = count_q;
	assign stat.room = count_q <= CNT_W'(FIFO_DEPTH - MAX_RES);

	// Write the new results at consecutive slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push_n)
				mem[PTR_W'(int'(wr_ptr_q) + i)] <= push_data[i];
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + push_n);
			if (pop)
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			count_q <= CNT_W'(count_q + push_n - CNT_W'(pop));
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/keyword_token_lexer.sv =====
// Keyword token lexer top level: input register, scan state and result queue.
//
// Input channel: one ASCII byte per transfer on ch (in_valid/in_ready);
// byte 0 marks end of input. Output channel: one result record per
// transfer (out_valid/out_ready): an echo of a token character or a
// close record with type, keyword index, length and truncated flag.
// last is set on the final record caused by a byte. A byte causes zero
// to three records; skipped bytes cause none.
// Path: an accepted byte is held in the input register, then its
// records are written to a four-entry queue whose head drives the
// output.
// Throughput: one byte per cycle while each byte gives at most one
// record and the receiver keeps up; the output port delivers one record
// per cycle while out_ready is high. The input register moves on only
// when the queue has room for three records.
// Reset clears the scan state to idle and empties the queue.
// When the receiver stalls, records wait in the queue and in_ready drops
// once the queue cannot take a full byte's worth.
`default_nettype none
`include "assert_macros.svh"
module keyword_token_lexer
	import klex_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] ch,
	output logic out_valid,
	input wire logic out_ready,
	output logic rec_kind,
	output logic [7:0] text_char,
	output logic [2:0] token_type,
	output logic [1:0] keyword_id,
	output logic [7:0] token_length,
	output logic truncated,
	output logic last
);
	logic [7:0] ch_s1;
	logic valid_s1;
	logic fire_s1;
	lex_state_t st_q;
	lex_state_t st_n;
	res_t step_res [MAX_RES];
	logic [1:0] step_n;
	logic [1:0] push_n;
	res_t head;
	fifo_stat_t stat;

	assign fire_s1 = valid_s1 && stat.room;
	assign in_ready = !valid_s1 || fire_s1;
	assign push_n = fire_s1 ? step_n : 2'd0;

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			ch_s1 <= ch;
	end

	// Track the input register and advance scan state per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= LEX_IDLE;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (fire_s1)
				valid_s1 <= 1'b0;
			if (fire_s1)
				st_q <= st_n;
		end
	end

	klex_step u_step (
		.ch(ch_s1),
		.st(st_q),
		.st_n(st_n),
		.res(step_res),
		.res_n(step_n)
	);

	klex_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(step_res),
		.push_n(push_n),
		.pop_ready(out_ready),
		.head_valid(out_valid),
		.head(head),
		.stat(stat)
	);

	// Drive the output fields from the queue head
	assign rec_kind = head.rec_kind;
	assign text_char = head.text_char;
	assign token_type = head.token_type;
	assign keyword_id = head.keyword_id;
	assign token_length = head.token_length;
	assign truncated = head.truncated;
	assign last = head.last;

	`KLEX_ASSERT_ALWAYS(a_fifo_bound, stat.count <= CNT_W'(FIFO_DEPTH), "result queue overrun")
	`KLEX_ASSERT_ALWAYS(a_run_bound, st_q.run_len <= RUN_LIMIT, "run length past limit")
	`KLEX_ASSERT_IMPLIES(a_idle_clear, st_q.mode == MODE_IDLE, st_q.run_len == '0 && !st_q.ovf, "idle state not cleared")
	`KLEX_ASSERT_IMPLIES(a_ovf_full, st_q.ovf, st_q.run_len == RUN_LIMIT, "overflow below limit")
	`KLEX_ASSERT_NEXT(a_stall_hold, valid_s1 && !stat.room, valid_s1 && $stable(ch_s1), "stalled byte lost")
endmodule
`default_nettype wire

// ===== tb/tb_keyword_token_lexer.sv =====
// Self-checking testbench for the keyword token lexer.
`default_nettype none
module tb_keyword_token_lexer;
	import klex_pkg::*;

	localparam int IDLE_LIMIT = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEMS_TARGET = 200;
	localparam logic [7:0] END_BYTE = 8'h00;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] ch = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic rec_kind;
	logic [7:0] text_char;
	logic [2:0] token_type;
	logic [1:0] keyword_id;
	logic [7:0] token_length;
	logic truncated;
	logic last;

	keyword_token_lexer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rec_kind(rec_kind),
		.text_char(text_char),
		.token_type(token_type),
		.keyword_id(keyword_id),
		.token_length(token_length),
		.truncated(truncated),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Bytes waiting to be sent, and records the lexer still owes
	logic [7:0] byte_q[$];
	res_t owed_recs[$];
	res_t byte_recs[$];

	// Tokenizer state mirrored by the testbench
	mode_t scan_state = MODE_IDLE;
	int unsigned tok_len = 0;
	logic [3:0] kw_alive = 4'hF;
	logic tok_cut = 1'b0;

	int err_count = 0;
	int rec_count = 0;
	int bytes_sent = 0;
	int trunc_count = 0;
	int close_count[5] = '{0, 0, 0, 0, 0};
	int idle_run = 0;

	// Keyword spellings, right aligned in 6 bytes
	function automatic logic [47:0] kw_spell(input int k);
		case (k)
			0: return "if";
			1: return "else";
			2: return "while";
			default: return "return";
		endcase
	endfunction

	function automatic int unsigned kw_size(input int k);
		case (k)
			0: return 2;
			1: return 4;
			2: return 5;
			default: return 6;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input int k, input int unsigned pos);
		logic [47:0] w;
		int unsigned n;
		w = kw_spell(k);
		n = kw_size(k);
		if (pos >= n)
			return 8'h00;
		return w[8 * (n - 1 - pos) +: 8];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// + - * /
	function automatic logic is_op(input logic [7:0] c);
		return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F;
	endfunction

	function automatic void add_rec(input logic kind, input logic [7:0] c,
			input logic [2:0] typ, input logic [1:0] kw, input int unsigned len,
			input logic cut);
		res_t r;
		r.rec_kind = kind;
		r.text_char = c;
		r.token_type = typ;
		r.keyword_id = kw;
		r.token_length = (len > 255) ? 8'd255 : len[7:0];
		r.truncated = cut;
		r.last = 1'b0;
		byte_recs.push_back(r);
	endfunction

	// Append one character to the open token; drop it past the length limit
	function automatic void grow_token(input logic [7:0] c, input logic [2:0] typ);
		if (tok_len >= TOKEN_LIMIT) begin
			tok_cut = 1'b1;
			return;
		end
		if (typ == TYPE_IDENT) begin
			for (int k = 0; k < 4; k++) begin
				if (kw_alive[k] && (tok_len >= kw_size(k) || kw_char(k, tok_len) != c))
					kw_alive[k] = 1'b0;
			end
		end
		tok_len++;
		add_rec(REC_ECHO, c, typ, 2'd0, 0, 1'b0);
	endfunction

	function automatic void close_token();
		logic [2:0] typ;
		logic [1:0] kw;
		typ = (scan_state == MODE_IDENT) ? TYPE_IDENT : TYPE_NUMBER;
		kw = 2'd0;
		if (typ == TYPE_IDENT && !tok_cut) begin
			for (int k = 0; k < 4; k++) begin
				if (typ == TYPE_IDENT && kw_alive[k] && tok_len == kw_size(k)) begin
					typ = TYPE_KEYWORD;
					kw = 2'(k);
				end
			end
		end
		add_rec(REC_CLOSE, 8'h00, typ, kw, tok_len, tok_cut);
		scan_state = MODE_IDLE;
		tok_len = 0;
		kw_alive = 4'hF;
		tok_cut = 1'b0;
	endfunction

	function automatic void open_token(input mode_t m);
		scan_state = m;
		tok_len = 0;
		kw_alive = 4'hF;
		tok_cut = 1'b0;
	endfunction

	// Work out the records one byte causes and append them to the owed list
	function automatic void lex_byte(input logic [7:0] c);
		res_t r;
		byte_recs.delete();
		if (scan_state == MODE_IDENT) begin
			if (is_letter(c) || is_digit(c))
				grow_token(c, TYPE_IDENT);
			else
				close_token();
		end else if (scan_state == MODE_NUMBER) begin
			if (is_digit(c))
				grow_token(c, TYPE_NUMBER);
			else
				close_token();
		end
		if (scan_state == MODE_IDLE) begin
			if (c == END_BYTE) begin
				add_rec(REC_CLOSE, 8'h00, TYPE_END, 2'd0, 0, 1'b0);
			end else if (is_letter(c)) begin
				open_token(MODE_IDENT);
				grow_token(c, TYPE_IDENT);
			end else if (is_digit(c)) begin
				open_token(MODE_NUMBER);
				grow_token(c, TYPE_NUMBER);
			end else if (is_op(c)) begin
				add_rec(REC_ECHO, c, TYPE_OPERATOR, 2'd0, 0, 1'b0);
				add_rec(REC_CLOSE, 8'h00, TYPE_OPERATOR, 2'd0, 1, 1'b0);
			end
		end
		if (byte_recs.size() != 0) begin
			r = byte_recs.pop_back();
			r.last = 1'b1;
			byte_recs.push_back(r);
		end
		while (byte_recs.size() != 0)
			owed_recs.push_back(byte_recs.pop_front());
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("record %0d: %s is 0x%h, expected 0x%h",
				rec_count, name, got, want));
	endtask

	// Stimulus helpers
	task automatic push_byte(input logic [7:0] c);
		byte_q.push_back(c);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_word(input int k, input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			push_byte(kw_char(k, i));
	endtask

	function automatic logic [7:0] rnd_letter();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h61, 8'h7A));
		return 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	function automatic logic [7:0] rnd_digit();
		return 8'($urandom_range(8'h30, 8'h39));
	endfunction

	function automatic logic [7:0] rnd_alnum();
		return ($urandom_range(0, 3) == 0) ? rnd_digit() : rnd_letter();
	endfunction

	// Space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic [7:0] rnd_space();
		case ($urandom_range(0, 5))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0A;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return 8'h0D;
		endcase
	endfunction

	function automatic logic [7:0] rnd_op();
		case ($urandom_range(0, 3))
			0: return 8'h2B;
			1: return 8'h2D;
			2: return 8'h2A;
			default: return 8'h2F;
		endcase
	endfunction

	// Queue one random token, mostly well formed, sometimes noise
	task automatic queue_random_token();
		int pick;
		int k;
		int n;
		int pos;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 3);
		if (pick < 15) begin
			push_word(k, kw_size(k));
		end else if (pick < 27) begin
			// near misses: keyword prefix, extension or one letter changed
			n = kw_size(k);
			case ($urandom_range(0, 2))
				0: push_word(k, $urandom_range(1, n - 1));
				1: begin
					push_word(k, n);
					push_byte(rnd_alnum());
				end
				default: begin
					pos = $urandom_range(0, n - 1);
					for (int i = 0; i < n; i++)
						push_byte(i == pos ? rnd_letter() : kw_char(k, i));
				end
			endcase
		end else if (pick < 42) begin
			n = $urandom_range(1, 10);
			push_byte(rnd_letter());
			for (int i = 1; i < n; i++)
				push_byte(rnd_alnum());
		end else if (pick < 57) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				push_byte(rnd_digit());
		end else if (pick < 70) begin
			push_byte(rnd_op());
		end else if (pick < 80) begin
			push_byte(rnd_space());
		end else if (pick < 93) begin
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			push_byte(END_BYTE);
		end
		if ($urandom_range(0, 1))
			push_byte(rnd_space());
	endtask

	// Input driver: one byte per transfer, random gap after each
	logic tx_burst = 1'b0;
	int tx_gap = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (byte_q.size() != 0) begin
				in_valid <= 1'b1;
				ch <= byte_q.pop_front();
				if ($urandom_range(0, 19) == 0)
					tx_burst = !tx_burst;
				tx_gap <= tx_burst ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stall after each transfer
	logic rx_burst = 1'b0;
	int rx_wait = 0;
	int rx_draw;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else if (!out_ready) begin
			if (rx_wait <= 1)
				out_ready <= 1'b1;
			rx_wait <= rx_wait - 1;
		end else if (out_valid) begin
			if ($urandom_range(0, 19) == 0)
				rx_burst = !rx_burst;
			rx_draw = rx_burst ? 0 : $urandom_range(0, 4);
			if (rx_draw != 0) begin
				out_ready <= 1'b0;
				rx_wait <= rx_draw;
			end
		end
	end

	// Monitor: predict on input transfers, check output transfers, watch for hangs
	res_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				lex_byte(ch);
				bytes_sent++;
			end
			if (out_valid && out_ready) begin
				if (owed_recs.size() == 0) begin
					report_mismatch($sformatf("record %0d arrived with nothing expected",
						rec_count));
				end else begin
					want = owed_recs.pop_front();
					check_field("rec_kind", 8'(rec_kind), 8'(want.rec_kind));
					check_field("text_char", text_char, want.text_char);
					check_field("token_type", 8'(token_type), 8'(want.token_type));
					check_field("keyword_id", 8'(keyword_id), 8'(want.keyword_id));
					check_field("token_length", token_length, want.token_length);
					check_field("truncated", 8'(truncated), 8'(want.truncated));
					check_field("last", 8'(last), 8'(want.last));
					if (want.rec_kind == REC_CLOSE && want.token_type <= TYPE_END)
						close_count[want.token_type]++;
					if (want.truncated)
						trunc_count++;
				end
				rec_count++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d records still owed",
					idle_run, owed_recs.size());
				$display("tb_keyword_token_lexer: FAIL");
				$finish;
			end
		end
	end

	initial begin
		// Keywords, adjacency of tokens, extremes of letters and digits
		push_text("if else+while return");
		push_byte(END_BYTE);
		push_text("Zz9 07a*/");
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(END_BYTE);
		push_byte(END_BYTE);

		while (byte_q.size() < ITEMS_TARGET)
			queue_random_token();
		push_byte(END_BYTE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || in_valid || owed_recs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (owed_recs.size() != 0)
			report_mismatch($sformatf("%0d records never arrived", owed_recs.size()));
		$display("sent %0d bytes, checked %0d records, %0d mismatches",
			bytes_sent, rec_count, err_count);
		$display("closed: %0d ident, %0d number, %0d op, %0d keyword, %0d end; %0d cut",
			close_count[0], close_count[1], close_count[2], close_count[3],
			close_count[4], trunc_count);
		if (err_count == 0)
			$display("tb_keyword_token_lexer: PASS");
		else
			$display("tb_keyword_token_lexer: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
